FILE: hw/rtl/mcache_pkg.sv
// Shared types, codes and constants of the per-CPU pointer magazine cache.
package mcache_pkg;

  // Field widths of the input and result transactions
  localparam int FUNC_W   = 2;
  localparam int CPU_W    = 8;
  localparam int SIZE_W   = 32;
  localparam int ADDR_W   = 48;
  localparam int STATUS_W = 3;
  localparam int CLS_W    = 3;
  localparam int WANT_W   = 5;

  // Magazine index carried between the front and back parts (fits 64 CPUs x 7 classes)
  localparam int MAG_IDX_W = 9;

  // Decoupling queue; depth must be a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);

  localparam logic [CLS_W-1:0] NO_CLASS = 3'd7;
  localparam logic [9:0] CLASS_LIMIT [7] = '{10'd8, 10'd16, 10'd32, 10'd64,
                                              10'd128, 10'd256, 10'd512};

  // Request function codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_REFILL = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_GRANTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BYP_ALOC = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BYP_FREE = 3'd3;
  localparam logic [STATUS_W-1:0] ST_STORED   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_DRAIN    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_REJECT   = 3'd6;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_REFILL
  } op_t;

  // Classified request handed from the front part to the back part
  typedef struct packed {
    op_t                  op;
    logic                 bypass;
    logic [CLS_W-1:0]     cls;
    logic [MAG_IDX_W-1:0] mag;
    logic [ADDR_W-1:0]    addr;
  } item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_GRANT,
    S_EMIT,
    S_DRAIN
  } back_state_t;

endpackage

FILE: hw/rtl/per_cpu_pointer_magazine_cache.sv
// Top level of the per-CPU pointer magazine cache.
//
// Keeps one LIFO magazine of object pointers for every pair of CPU and size class
// (classes of 8..512 bytes). Alloc transactions pop a pointer or report a miss that
// asks the global allocator for BATCH_SIZE objects; free and refill transactions push.
// A free to a full magazine first returns the top MAG_DEPTH/2 pointers as drain
// results, the final one marked with last. Disabled cache, oversize requests, CPU ids
// at or above CPU_COUNT and null pointers go straight back as bypass or reject results.
// The front part classifies each transaction and places it in a two-entry queue; the
// back part works through the queue one transaction at a time against a fill-count
// memory and an entry memory, both with registered reads. A bypass passes from the
// idle state straight to the result state; a hit alloc goes through the lookup state
// (fill read) and the grant state (entry read), and a store, miss or reject through
// the lookup state only; a drain emits one result per entry read. After reset the
// back part clears every fill count with in_ready low; cfg writes are taken throughout.
// Write cfg_wr_data (cache enable, reset 0) only while the block is idle.
module per_cpu_pointer_magazine_cache #(
  parameter int CPU_COUNT   = 8,
  parameter int CLASS_COUNT = 7,
  parameter int MAG_DEPTH   = 32,
  parameter int BATCH_SIZE  = 16,
  parameter int ADDR_BITS   = 48
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_wr_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [mcache_pkg::FUNC_W-1:0]   in_func,
  input  logic [mcache_pkg::CPU_W-1:0]    in_cpu_id,
  input  logic [mcache_pkg::SIZE_W-1:0]   in_size_bytes,
  input  logic [mcache_pkg::ADDR_W-1:0]   in_object_address,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mcache_pkg::STATUS_W-1:0] out_status,
  output logic [mcache_pkg::ADDR_W-1:0]   out_address_out,
  output logic [mcache_pkg::CLS_W-1:0]    out_size_class,
  output logic [mcache_pkg::WANT_W-1:0]   out_refill_wanted,
  output logic                            out_last
);

  logic              cache_enable_r;
  logic              clearing;
  logic              q_push, q_full, q_pop, q_valid;
  mcache_pkg::item_t q_wr_item, q_rd_item;

  // Hold the enable bit; the front part samples it per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_enable_r <= 1'b0;
    end else if (cfg_wr_en) begin
      cache_enable_r <= cfg_wr_data;
    end
  end

  mcache_front #(
    .CPU_COUNT   (CPU_COUNT),
    .CLASS_COUNT (CLASS_COUNT),
    .ADDR_BITS   (ADDR_BITS)
  ) u_front (
    .clearing          (clearing),
    .cache_enable      (cache_enable_r),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_cpu_id         (in_cpu_id),
    .in_size_bytes     (in_size_bytes),
    .in_object_address (in_object_address),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_item            (q_wr_item)
  );

  // Decouple classification from the magazine sequencer
  mcache_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .rd_item (q_rd_item)
  );

  mcache_back #(
    .CPU_COUNT   (CPU_COUNT),
    .CLASS_COUNT (CLASS_COUNT),
    .MAG_DEPTH   (MAG_DEPTH),
    .BATCH_SIZE  (BATCH_SIZE),
    .ADDR_BITS   (ADDR_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_rd_item),
    .q_pop             (q_pop),
    .clearing          (clearing),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_address_out   (out_address_out),
    .out_size_class    (out_size_class),
    .out_refill_wanted (out_refill_wanted),
    .out_last          (out_last)
  );

endmodule

FILE: hw/rtl/mcache_front.sv
// Front part: accepts request transactions, finds the size class and the bypass cases.
module mcache_front #(
  parameter int CPU_COUNT   = 8,
  parameter int CLASS_COUNT = 7,
  parameter int ADDR_BITS   = 48
) (
  input  logic                              clearing,
  input  logic                              cache_enable,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mcache_pkg::FUNC_W-1:0]     in_func,
  input  logic [mcache_pkg::CPU_W-1:0]      in_cpu_id,
  input  logic [mcache_pkg::SIZE_W-1:0]     in_size_bytes,
  input  logic [mcache_pkg::ADDR_W-1:0]     in_object_address,
  input  logic                              q_full,
  output logic                              q_push,
  output mcache_pkg::item_t                 q_item
);

  localparam logic [mcache_pkg::ADDR_W-1:0] ADDR_MASK =
    (ADDR_BITS >= mcache_pkg::ADDR_W) ? {mcache_pkg::ADDR_W{1'b1}}
                                      : mcache_pkg::ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

  logic [mcache_pkg::CLS_W-1:0]  cls;
  logic                          cpu_ok;
  logic                          usable;
  logic [mcache_pkg::ADDR_W-1:0] addr_m;
  logic                          addr_zero;
  logic [11:0]                   mag_full;
  logic                          func_ok;
  mcache_pkg::op_t               op;
  logic                          bypass;

  // First class that holds the size; scan downwards so the lowest match wins
  always_comb begin
    cls = mcache_pkg::NO_CLASS;
    for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
      if (in_size_bytes <= mcache_pkg::SIZE_W'(mcache_pkg::CLASS_LIMIT[i])) begin
        cls = mcache_pkg::CLS_W'(i);
      end
    end
  end

  assign cpu_ok    = {1'b0, in_cpu_id} < 9'(CPU_COUNT);
  assign usable    = cache_enable && (cls != mcache_pkg::NO_CLASS) && cpu_ok;
  assign addr_m    = in_object_address & ADDR_MASK;
  assign addr_zero = (addr_m == '0);
  assign mag_full  = 12'(in_cpu_id) * 12'(CLASS_COUNT) + 12'(cls);

  always_comb begin
    unique case (in_func)
      mcache_pkg::FUNC_ALLOC: begin
        func_ok = 1'b1;
        op      = mcache_pkg::OP_ALLOC;
        bypass  = !usable;
      end
      mcache_pkg::FUNC_FREE: begin
        func_ok = 1'b1;
        op      = mcache_pkg::OP_FREE;
        bypass  = !usable || addr_zero;
      end
      mcache_pkg::FUNC_REFILL: begin
        func_ok = 1'b1;
        op      = mcache_pkg::OP_REFILL;
        bypass  = !usable || addr_zero;
      end
      default: begin
        // Unused code: take the transaction and drop it
        func_ok = 1'b0;
        op      = mcache_pkg::OP_ALLOC;
        bypass  = 1'b1;
      end
    endcase
  end

  assign in_ready = !clearing && !q_full;
  assign q_push   = in_valid && in_ready && func_ok;

  assign q_item.op     = op;
  assign q_item.bypass = bypass;
  assign q_item.cls    = cls;
  assign q_item.mag    = mcache_pkg::MAG_IDX_W'(mag_full);
  assign q_item.addr   = addr_m;

endmodule

FILE: hw/rtl/mcache_fifo.sv
// Short queue of classified requests between the front and back parts.
module mcache_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mcache_pkg::item_t wr_item,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output mcache_pkg::item_t rd_item
);

  mcache_pkg::item_t                 slot_r [mcache_pkg::QUEUE_DEPTH];
  logic [mcache_pkg::Q_PTR_W-1:0]    wr_ptr_r;
  logic [mcache_pkg::Q_PTR_W-1:0]    rd_ptr_r;
  logic [mcache_pkg::Q_PTR_W:0]      count_r;
  logic [mcache_pkg::Q_PTR_W:0]      count_nxt;

  assign full    = (count_r == (mcache_pkg::Q_PTR_W + 1)'(mcache_pkg::QUEUE_DEPTH));
  assign valid   = (count_r != '0);
  assign rd_item = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

FILE: hw/rtl/mcache_back.sv
// Back part: magazine memories, fill counts and the sequencer that produces results.
module mcache_back #(
  parameter int CPU_COUNT   = 8,
  parameter int CLASS_COUNT = 7,
  parameter int MAG_DEPTH   = 32,
  parameter int BATCH_SIZE  = 16,
  parameter int ADDR_BITS   = 48
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  mcache_pkg::item_t               q_item,
  output logic                            q_pop,
  output logic                            clearing,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [mcache_pkg::STATUS_W-1:0] out_status,
  output logic [mcache_pkg::ADDR_W-1:0]   out_address_out,
  output logic [mcache_pkg::CLS_W-1:0]    out_size_class,
  output logic [mcache_pkg::WANT_W-1:0]   out_refill_wanted,
  output logic                            out_last
);

  localparam int NMAG     = CPU_COUNT * CLASS_COUNT;
  localparam int MAG_W    = (NMAG > 1) ? $clog2(NMAG) : 1;
  localparam int NENT     = NMAG * MAG_DEPTH;
  localparam int ENT_W    = $clog2(NENT);
  localparam int IDX_W    = $clog2(MAG_DEPTH);
  localparam int FILL_W   = $clog2(MAG_DEPTH + 1);
  localparam int HALF     = MAG_DEPTH / 2;
  localparam int LAST_IDX = MAG_DEPTH - HALF;
  localparam int STORE_W  = (ADDR_BITS < mcache_pkg::ADDR_W) ? ADDR_BITS : mcache_pkg::ADDR_W;
  localparam int WANT     = (BATCH_SIZE > 31) ? 31 : BATCH_SIZE;

  mcache_pkg::back_state_t state_r, state_nxt;
  mcache_pkg::item_t       item_r, item_nxt;
  logic [ENT_W-1:0]        base_r, base_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [mcache_pkg::STATUS_W-1:0] pend_r, pend_nxt;
  logic [MAG_W-1:0]        clr_r, clr_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [mcache_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [mcache_pkg::ADDR_W-1:0]   out_addr_r, out_addr_nxt;
  logic [mcache_pkg::CLS_W-1:0]    out_cls_r, out_cls_nxt;
  logic [mcache_pkg::WANT_W-1:0]   out_want_r, out_want_nxt;
  logic                            out_last_r, out_last_nxt;
  logic                            out_free;

  // Fill-count memory
  logic [FILL_W-1:0] fill_mem [NMAG];
  logic              fill_we, fill_re;
  logic [MAG_W-1:0]  fill_waddr, fill_raddr;
  logic [FILL_W-1:0] fill_wdata, fill_rd_r;
  logic [FILL_W-1:0] fill_dec, fill_inc;

  // Magazine entry memory
  logic [STORE_W-1:0] ent_mem [NENT];
  logic               ent_we, ent_re;
  logic [ENT_W-1:0]   ent_waddr, ent_raddr;
  logic [STORE_W-1:0] ent_wdata, ent_rd_r;

  logic drain_last;

  assign out_free   = !out_valid_r || out_ready;
  assign clearing   = (state_r == mcache_pkg::S_CLEAR);
  assign fill_dec   = FILL_W'(fill_rd_r - FILL_W'(1));
  assign fill_inc   = FILL_W'(fill_rd_r + FILL_W'(1));
  assign drain_last = (idx_r == IDX_W'(LAST_IDX));

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    base_nxt       = base_r;
    idx_nxt        = idx_r;
    pend_nxt       = pend_r;
    clr_nxt        = clr_r;
    q_pop          = 1'b0;
    fill_we        = 1'b0;
    fill_re        = 1'b0;
    fill_waddr     = item_r.mag[MAG_W-1:0];
    fill_raddr     = q_item.mag[MAG_W-1:0];
    fill_wdata     = fill_inc;
    ent_we         = 1'b0;
    ent_re         = 1'b0;
    ent_waddr      = base_r + ENT_W'(fill_rd_r);
    ent_wdata      = item_r.addr[STORE_W-1:0];
    ent_raddr      = base_r + ENT_W'(fill_dec);
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_cls_nxt    = out_cls_r;
    out_want_nxt   = out_want_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      mcache_pkg::S_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_r;
        fill_wdata = '0;
        clr_nxt    = clr_r + 1'b1;
        if (clr_r == MAG_W'(NMAG - 1)) begin
          state_nxt = mcache_pkg::S_IDLE;
        end
      end
      mcache_pkg::S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          fill_re  = 1'b1;
          base_nxt = ENT_W'(ENT_W'(q_item.mag[MAG_W-1:0]) * ENT_W'(MAG_DEPTH));
          if (q_item.bypass) begin
            unique case (q_item.op)
              mcache_pkg::OP_ALLOC:  pend_nxt = mcache_pkg::ST_BYP_ALOC;
              mcache_pkg::OP_FREE:   pend_nxt = mcache_pkg::ST_BYP_FREE;
              mcache_pkg::OP_REFILL: pend_nxt = mcache_pkg::ST_REJECT;
              default:               pend_nxt = mcache_pkg::ST_REJECT;
            endcase
            state_nxt = mcache_pkg::S_EMIT;
          end else begin
            state_nxt = mcache_pkg::S_LOOK;
          end
        end
      end
      mcache_pkg::S_LOOK: begin
        unique case (item_r.op)
          mcache_pkg::OP_ALLOC: begin
            if (fill_rd_r == '0) begin
              pend_nxt  = mcache_pkg::ST_MISS;
              state_nxt = mcache_pkg::S_EMIT;
            end else begin
              fill_we    = 1'b1;
              fill_wdata = fill_dec;
              ent_re     = 1'b1;
              state_nxt  = mcache_pkg::S_GRANT;
            end
          end
          mcache_pkg::OP_FREE: begin
            if (fill_rd_r == FILL_W'(MAG_DEPTH)) begin
              idx_nxt   = IDX_W'(MAG_DEPTH - 1);
              ent_re    = 1'b1;
              ent_raddr = base_r + ENT_W'(MAG_DEPTH - 1);
              state_nxt = mcache_pkg::S_DRAIN;
            end else begin
              ent_we    = 1'b1;
              fill_we   = 1'b1;
              pend_nxt  = mcache_pkg::ST_STORED;
              state_nxt = mcache_pkg::S_EMIT;
            end
          end
          mcache_pkg::OP_REFILL: begin
            if (fill_rd_r == FILL_W'(MAG_DEPTH)) begin
              pend_nxt  = mcache_pkg::ST_REJECT;
            end else begin
              ent_we    = 1'b1;
              fill_we   = 1'b1;
              pend_nxt  = mcache_pkg::ST_STORED;
            end
            state_nxt = mcache_pkg::S_EMIT;
          end
          default: begin
            state_nxt = mcache_pkg::S_IDLE;
          end
        endcase
      end
      mcache_pkg::S_GRANT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = mcache_pkg::ST_GRANTED;
          out_addr_nxt   = mcache_pkg::ADDR_W'(ent_rd_r);
          out_cls_nxt    = item_r.cls;
          out_want_nxt   = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = mcache_pkg::S_IDLE;
        end
      end
      mcache_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = pend_r;
          out_addr_nxt   = (pend_r == mcache_pkg::ST_BYP_FREE ||
                            pend_r == mcache_pkg::ST_REJECT) ? item_r.addr : '0;
          out_cls_nxt    = item_r.cls;
          out_want_nxt   = (pend_r == mcache_pkg::ST_MISS) ? mcache_pkg::WANT_W'(WANT) : '0;
          out_last_nxt   = 1'b1;
          state_nxt      = mcache_pkg::S_IDLE;
        end
      end
      mcache_pkg::S_DRAIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = mcache_pkg::ST_DRAIN;
          out_addr_nxt   = mcache_pkg::ADDR_W'(ent_rd_r);
          out_cls_nxt    = item_r.cls;
          out_want_nxt   = '0;
          out_last_nxt   = drain_last;
          if (drain_last) begin
            // Push the freed pointer into the slot just vacated
            ent_we     = 1'b1;
            ent_waddr  = base_r + ENT_W'(idx_r);
            fill_we    = 1'b1;
            fill_wdata = FILL_W'(LAST_IDX + 1);
            state_nxt  = mcache_pkg::S_IDLE;
          end else begin
            idx_nxt   = IDX_W'(idx_r - IDX_W'(1));
            ent_re    = 1'b1;
            ent_raddr = base_r + ENT_W'(IDX_W'(idx_r - IDX_W'(1)));
          end
        end
      end
      default: begin
        state_nxt = mcache_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mcache_pkg::S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    base_r       <= base_nxt;
    idx_r        <= idx_nxt;
    pend_r       <= pend_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_cls_r    <= out_cls_nxt;
    out_want_r   <= out_want_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    if (fill_re) begin
      fill_rd_r <= fill_mem[fill_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rd_r <= ent_mem[ent_raddr];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_address_out   = out_addr_r;
  assign out_size_class    = out_cls_r;
  assign out_refill_wanted = out_want_r;
  assign out_last          = out_last_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_we |-> fill_wdata <= FILL_W'(MAG_DEPTH))
    else $error("fill count written above magazine depth");

  a_drain_idx: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mcache_pkg::S_DRAIN |-> idx_r >= IDX_W'(LAST_IDX))
    else $error("drain ran past half of the magazine");

  a_ent_port: assert property (@(posedge clk) disable iff (!rst_n)
    (ent_we && ent_re) |-> ent_waddr != ent_raddr)
    else $error("entry read and write collide");

  a_clear_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mcache_pkg::S_CLEAR && state_nxt != mcache_pkg::S_CLEAR)
      |-> clr_r == MAG_W'(NMAG - 1))
    else $error("clearing pass left early");

  a_look_once: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mcache_pkg::S_LOOK |=> state_r != mcache_pkg::S_LOOK)
    else $error("lookup state held for more than one cycle");

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the per-CPU pointer magazine cache.
module tb_top;
  import mcache_pkg::*;

  // Geometry of the block under test; the predictor keeps its own copy of the state
  localparam int CPUS         = 8;
  localparam int CLASSES      = 7;
  localparam int DEPTH        = 32;
  localparam int BATCH        = 16;
  localparam int ABITS        = 48;
  localparam int MAGS         = CPUS * CLASSES;
  localparam int LIMIT_CYCLES = 400000;

  // Function code that the block ignores, and the class reported for an unfit size
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [CLS_W-1:0]  CLASS_NONE  = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   addr;
    logic [CLS_W-1:0]    cls;
    logic [WANT_W-1:0]   want;
    logic                last;
  } cache_result_t;

  // Scoreboard: mirrors the magazines, predicts the results of each accepted
  // request transaction and checks every result transaction in order.
  class magazine_scoreboard;
    bit                cache_on;
    int unsigned       fill_count [MAGS];
    logic [ADDR_W-1:0] slot [MAGS*DEPTH];
    cache_result_t     awaited [$];
    int                mismatch_count;
    int                result_count;

    function new();
      cache_on       = 1'b0;
      mismatch_count = 0;
      result_count   = 0;
      foreach (fill_count[i]) fill_count[i] = 0;
    endfunction

    // Classes are 8 << index bytes; the first one that holds the size wins
    function logic [CLS_W-1:0] class_of_size(logic [SIZE_W-1:0] size);
      for (int i = 0; i < CLASSES; i++) begin
        if (size <= (32'd8 << i)) return i[CLS_W-1:0];
      end
      return CLASS_NONE;
    endfunction

    function void await_result(logic [STATUS_W-1:0] status, logic [ADDR_W-1:0] addr,
                               logic [CLS_W-1:0] cls, logic [WANT_W-1:0] want,
                               logic last);
      cache_result_t r;
      r.status = status;
      r.addr   = addr;
      r.cls    = cls;
      r.want   = want;
      r.last   = last;
      awaited.push_back(r);
    endfunction

    function void note_request(logic [FUNC_W-1:0] func, logic [CPU_W-1:0] cpu,
                               logic [SIZE_W-1:0] size, logic [ADDR_W-1:0] addr);
      logic [CLS_W-1:0]  cls;
      logic [WANT_W-1:0] want;
      bit                usable;
      int                mag;
      int                depth;
      cls    = class_of_size(size);
      want   = (BATCH > 31) ? 5'd31 : BATCH[WANT_W-1:0];
      usable = cache_on && (cls != CLASS_NONE) && (cpu < CPUS);
      mag    = 0;
      depth  = 0;
      if (usable) begin
        mag   = cpu * CLASSES + cls;
        depth = fill_count[mag];
      end
      case (func)
        FUNC_ALLOC: begin
          if (!usable) begin
            await_result(ST_BYP_ALOC, '0, cls, '0, 1'b1);
          end else if (depth == 0) begin
            await_result(ST_MISS, '0, cls, want, 1'b1);
          end else begin
            depth--;
            fill_count[mag] = depth;
            await_result(ST_GRANTED, slot[mag*DEPTH + depth], cls, '0, 1'b1);
          end
        end
        FUNC_FREE: begin
          if (!usable || addr == '0) begin
            await_result(ST_BYP_FREE, addr, cls, '0, 1'b1);
          end else if (depth < DEPTH) begin
            slot[mag*DEPTH + depth] = addr;
            fill_count[mag] = depth + 1;
            await_result(ST_STORED, '0, cls, '0, 1'b1);
          end else begin
            for (int i = 0; i < DEPTH/2; i++) begin
              depth--;
              await_result(ST_DRAIN, slot[mag*DEPTH + depth], cls, '0, i == DEPTH/2 - 1);
            end
            slot[mag*DEPTH + depth] = addr;
            fill_count[mag] = depth + 1;
          end
        end
        FUNC_REFILL: begin
          if (!usable || addr == '0 || depth >= DEPTH) begin
            await_result(ST_REJECT, addr, cls, '0, 1'b1);
          end else begin
            slot[mag*DEPTH + depth] = addr;
            fill_count[mag] = depth + 1;
            await_result(ST_STORED, '0, cls, '0, 1'b1);
          end
        end
        default: ;
      endcase
    endfunction

    // Print one line per mismatch and count it
    task report_mismatch(string what);
      mismatch_count++;
      $display("MISMATCH result %0d: %s", result_count, what);
    endtask

    task check_result(logic [STATUS_W-1:0] status, logic [ADDR_W-1:0] addr,
                      logic [CLS_W-1:0] cls, logic [WANT_W-1:0] want, logic last);
      cache_result_t exp;
      result_count++;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("status %0d arrived with nothing outstanding", status));
        return;
      end
      exp = awaited.pop_front();
      if (status !== exp.status)
        report_mismatch($sformatf("status %0d, wanted %0d", status, exp.status));
      if (addr !== exp.addr)
        report_mismatch($sformatf("address %h, wanted %h", addr, exp.addr));
      if (cls !== exp.cls)
        report_mismatch($sformatf("size class %0d, wanted %0d", cls, exp.cls));
      if (want !== exp.want)
        report_mismatch($sformatf("refill count %0d, wanted %0d", want, exp.want));
      if (last !== exp.last)
        report_mismatch($sformatf("last %0d, wanted %0d", last, exp.last));
    endtask
  endclass

  // Every input of the block holds a known value from time zero
  logic                clk               = 1'b0;
  logic                rst_n             = 1'b0;
  logic                cfg_wr_en         = 1'b0;
  logic                cfg_wr_data       = 1'b0;
  logic                in_valid          = 1'b0;
  logic [FUNC_W-1:0]   in_func           = '0;
  logic [CPU_W-1:0]    in_cpu_id         = '0;
  logic [SIZE_W-1:0]   in_size_bytes     = '0;
  logic [ADDR_W-1:0]   in_object_address = '0;
  logic                out_ready         = 1'b0;
  logic                in_ready;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [ADDR_W-1:0]   out_address_out;
  logic [CLS_W-1:0]    out_size_class;
  logic [WANT_W-1:0]   out_refill_wanted;
  logic                out_last;

  // Idling rates of the two sides, in cycles per hundred
  int          send_idle_pct  = 20;
  int          recv_stall_pct = 69;
  int unsigned cycle_count    = 0;

  // Two hot magazines take most of the well-formed traffic so that they fill and drain
  int hot_cpu   [2];
  int hot_class [2];

  magazine_scoreboard board;

  per_cpu_pointer_magazine_cache #(
    .CPU_COUNT  (CPUS),
    .CLASS_COUNT(CLASSES),
    .MAG_DEPTH  (DEPTH),
    .BATCH_SIZE (BATCH),
    .ADDR_BITS  (ABITS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_cpu_id        (in_cpu_id),
    .in_size_bytes    (in_size_bytes),
    .in_object_address(in_object_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_address_out  (out_address_out),
    .out_size_class   (out_size_class),
    .out_refill_wanted(out_refill_wanted),
    .out_last         (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the result side at random; a rate of zero keeps ready high throughout
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Check each result transaction at the edge that accepts it
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result(out_status, out_address_out, out_size_class, out_refill_wanted,
                         out_last);
  end

  // Watchdog: end a hung run well beyond the slowest correct one
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("** per_cpu_pointer_magazine_cache: FAILED **");
      $finish;
    end
  end

  // Offer one request transaction, with random idle cycles first, and note it
  // in the scoreboard once accepted. Enter and leave at a falling edge; valid is
  // only lowered when the sender idles, so back-to-back items keep it high.
  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [CPU_W-1:0] c,
                              input logic [SIZE_W-1:0] s, input logic [ADDR_W-1:0] a);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid          <= 1'b1;
    in_func           <= f;
    in_cpu_id         <= c;
    in_size_bytes     <= s;
    in_object_address <= a;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(f, c, s, a);
    @(negedge clk);
  endtask

  // Drop valid and hold until every predicted result has come back, then let the
  // block settle before the caller goes on
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (board.awaited.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_cache_enable(input bit on);
    wait_quiet();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= on;
    @(negedge clk);
    cfg_wr_en     <= 1'b0;
    board.cache_on = on;
  endtask

  // Any size that falls into class c, boundaries included
  function automatic logic [SIZE_W-1:0] size_for_class(input int c);
    logic [SIZE_W-1:0] lo;
    logic [SIZE_W-1:0] hi;
    hi = 32'd8 << c;
    lo = (c == 0) ? 32'd0 : (32'd4 << c) + 32'd1;
    return $urandom_range(hi, lo);
  endfunction

  function automatic logic [ADDR_W-1:0] random_address();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[ADDR_W-1:0];
  endfunction

  // Random traffic in bursts: fill bursts push hard onto one hot magazine (and
  // so reach full stacks, drains and rejected refills), empty bursts pop it
  // back to misses, and noise bursts draw every field at random. Ignored
  // transactions do not count towards the total.
  task automatic run_random(input int count);
    int                sent;
    int                kind;
    int                len;
    int                pick;
    logic [FUNC_W-1:0] f;
    logic [CPU_W-1:0]  c;
    logic [SIZE_W-1:0] s;
    logic [ADDR_W-1:0] a;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(0, 9);
      pick = $urandom_range(0, 1);
      len  = (kind < 5) ? $urandom_range(16, 40) : $urandom_range(4, 16);
      for (int i = 0; i < len && sent < count; i++) begin
        c = CPU_W'(hot_cpu[pick]);
        s = size_for_class(hot_class[pick]);
        a = random_address();
        if (kind < 5) begin
          if ($urandom_range(0, 9) < 8)
            f = ($urandom_range(0, 3) == 0) ? FUNC_REFILL : FUNC_FREE;
          else
            f = FUNC_ALLOC;
        end else if (kind < 7) begin
          f = ($urandom_range(0, 9) < 8) ? FUNC_ALLOC : FUNC_FREE;
        end else begin
          f = FUNC_W'($urandom_range(0, 3));
          c = ($urandom_range(0, 9) < 7) ? CPU_W'($urandom_range(0, CPUS-1))
                                         : CPU_W'($urandom_range(CPUS, 255));
          s = ($urandom_range(0, 3) == 0) ? $urandom : size_for_class($urandom_range(0, 6));
          if ($urandom_range(0, 9) == 0) a = '0;
        end
        send_request(f, c, s, a);
        if (f != FUNC_UNUSED) sent++;
      end
    end
  endtask

  initial begin
    board        = new();
    hot_cpu[0]   = $urandom_range(0, CPUS-1);
    hot_cpu[1]   = $urandom_range(0, CPUS-1);
    hot_class[0] = $urandom_range(0, CLASSES-1);
    hot_class[1] = $urandom_range(0, CLASSES-1);

    // Hold reset, then release it; the block then clears its fill
    // counts with in_ready low, which the handshake simply waits out
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Disabled cache: every request bypasses or is rejected
    set_cache_enable(1'b0);
    send_request(FUNC_ALLOC,  8'd0, 32'd8, '0);
    send_request(FUNC_FREE,   8'd0, 32'd8, {ADDR_W{1'b1}});
    send_request(FUNC_REFILL, 8'd0, 32'd8, 48'h0000_1234_5678);

    // Enabled: miss on empty, refill, free, pops in LIFO order, then empty again
    set_cache_enable(1'b1);
    send_request(FUNC_ALLOC,  8'd0, 32'd0, '0);
    send_request(FUNC_REFILL, 8'd0, 32'd0, {ADDR_W{1'b1}});
    send_request(FUNC_FREE,   8'd0, 32'd1, 48'h1);
    send_request(FUNC_ALLOC,  8'd0, 32'd8, '0);
    send_request(FUNC_ALLOC,  8'd0, 32'd5, '0);
    send_request(FUNC_ALLOC,  8'd0, 32'd8, '0);
    // Largest class on the last CPU
    send_request(FUNC_ALLOC,  8'd7, 32'd512, '0);
    send_request(FUNC_FREE,   8'd7, 32'd257, 48'h8000_0000_0000);
    send_request(FUNC_ALLOC,  8'd7, 32'd300, '0);
    // CPU out of range and sizes that fit no class
    send_request(FUNC_ALLOC,  8'd8,   32'd8,   '0);
    send_request(FUNC_ALLOC,  8'd255, 32'd513, '0);
    send_request(FUNC_FREE,   8'd3,   32'd513, 48'h5555_5555_5555);
    send_request(FUNC_FREE,   8'd3,   32'hFFFF_FFFF, 48'hAAAA_AAAA_AAAA);
    // Null pointers bypass on free and are rejected on refill
    send_request(FUNC_FREE,   8'd3,   32'd64, '0);
    send_request(FUNC_REFILL, 8'd3,   32'd64, '0);
    send_request(FUNC_REFILL, 8'd200, 32'd64, 48'h5);
    // Unused function code: no result at all
    send_request(FUNC_UNUSED, 8'd0, 32'd8, 48'h1);
    // Class boundaries either side of 16 and 128
    send_request(FUNC_REFILL, 8'd5, 32'd128, 48'h0F0F_0F0F_0F0F);
    send_request(FUNC_FREE,   8'd5, 32'd17,  48'hF0F0_F0F0_F0F0);
    send_request(FUNC_ALLOC,  8'd5, 32'd16,  '0);
    send_request(FUNC_REFILL, 8'd5, 32'd9,   48'h0000_0000_0100);
    send_request(FUNC_ALLOC,  8'd5, 32'd129, '0);

    // Slow sender, heavily stalled receiver
    run_random(150);

    // A short stretch with the cache off, then back on with state intact
    set_cache_enable(1'b0);
    run_random(20);
    set_cache_enable(1'b1);

    // Heavily idling sender, lightly stalled receiver
    send_idle_pct  = 69;
    recv_stall_pct = 20;
    run_random(130);

    // Neither side idles
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(60);

    // Drain every outstanding result, then leave time for any stray one
    wait_quiet();
    repeat (16) @(negedge clk);
    if (board.mismatch_count == 0)
      $display("** per_cpu_pointer_magazine_cache: PASSED **");
    else
      $display("** per_cpu_pointer_magazine_cache: FAILED **");
    $finish;
  end

endmodule
